// ===== hw/rtl/sha_pkg.sv =====
// SHA-256 stream hasher package: round constants, initial hash values,
// controller/datapath command and status structs. No dependencies.
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  typedef logic [31:0] word_t;

  function automatic word_t round_const(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  // Controller -> datapath.
  typedef struct packed {
    logic       push;       // write push_byte into the block buffer
    logic [7:0] push_byte;
    logic       add_len;    // add in_count to the length counter
    logic       rnd_start;  // load round vars and schedule from chain/buffer
    logic       rnd_step;   // run one round
    logic       fold;       // add round vars into chain hash
    logic       restart;    // chain <- IV, length <- 0, fill <- 0
  } sha_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic [5:0]  fill;
    logic [63:0] bit_len;
    logic [5:0]  round;
  } sha_sts_t;

endpackage

// ===== hw/rtl/sha_datapath.sv =====
// SHA-256 datapath: block buffer, length counter, chaining hash and a
// one-round-per-cycle compression unit. Depends on sha_pkg.
module sha_datapath import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  input  logic [2:0]  in_count_i,
  input  logic [2:0]  rd_idx_i,
  output word_t       rd_word_o,
  output sha_sts_t    sts_o
);

  word_t       buf_q [BlockWords];
  word_t       w_q   [BlockWords];
  word_t       v_q   [8];
  word_t       h_q   [8];
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;

  logic [3:0]  wpos;
  logic [1:0]  bpos;
  assign wpos = fill_q[5:2];
  assign bpos = fill_q[1:0];

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Schedule window shifts by one each round; w_q[0] is the current word.
  word_t w_new, sw, t1, t2, s0, s1, ch, mj, ss0, ss1;
  always_comb begin
    s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    sw    = w_q[0];
    ss1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1    = v_q[7] + ss1 + ch + round_const(rnd_q) + sw;
    ss0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = ss0 + mj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      case (bpos)
        2'd0:    buf_q[wpos] <= {cmd_i.push_byte, 24'h0};
        2'd1:    buf_q[wpos][23:16] <= cmd_i.push_byte;
        2'd2:    buf_q[wpos][15:8] <= cmd_i.push_byte;
        default: buf_q[wpos][7:0] <= cmd_i.push_byte;
      endcase
    end
    if (cmd_i.rnd_start) begin
      // The last byte of the block is pushed this same cycle; forward it.
      for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= buf_q[i];
      w_q[BlockWords-1] <= {buf_q[BlockWords-1][31:8], cmd_i.push_byte};
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.rnd_step) begin
      for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i+1];
      w_q[BlockWords-1] <= w_new;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
        fill_q <= '0;
        len_q  <= '0;
      end else begin
        if (cmd_i.fold) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        if (cmd_i.push) fill_q <= fill_q + 6'd1;
        if (cmd_i.add_len) len_q <= len_q + 64'(in_count_i);
      end
      if (cmd_i.rnd_start) rnd_q <= '0;
      else if (cmd_i.rnd_step) rnd_q <= rnd_q + 6'd1;
    end
  end

  assign rd_word_o     = h_q[rd_idx_i];
  assign sts_o.fill    = fill_q;
  assign sts_o.bit_len = {len_q[60:0], 3'b000};
  assign sts_o.round   = rnd_q;

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// SHA-256 controller: feeds bytes and padding one per cycle, sequences the
// 64 rounds and the eight-word digest readout. Depends on sha_pkg.
module sha_ctrl import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_word_i,
  input  logic [2:0]  in_count_i,
  input  logic        in_final_i,
  output logic [2:0]  in_count_o,
  input  sha_sts_t    sts_i,
  output sha_cmd_t    cmd_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_idx_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StBytes = 3'd1;
  localparam logic [2:0] StPad   = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StFold  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  cnt_q, cnt_d;     // bytes left to push
  logic        fin_q, fin_d;
  logic        pad_q, pad_d;     // padding phase under way
  logic        ret_q, ret_d;     // state after fold: 0 bytes/idle/pad, 1 pad/out
  logic [2:0]  oi_q, oi_d;
  logic [63:0] blen_q, blen_d;
  logic [3:0]  pcnt_q, pcnt_d;   // padding byte index: 0 = 0x80, 1..8 length
  logic [2:0]  sat;
  logic        last_push;
  logic [7:0]  pbyte;

  assign sat        = (in_count_i > 3'd4) ? 3'd4 : in_count_i;
  assign in_count_o = sat;
  assign in_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign out_idx_o  = oi_q;
  assign last_push  = (sts_i.fill == 6'd63);

  always_comb begin
    st_d = st_q; word_d = word_q; cnt_d = cnt_q; fin_d = fin_q;
    pad_d = pad_q; ret_d = ret_q; oi_d = oi_q; blen_d = blen_q; pcnt_d = pcnt_q;
    cmd_o = '0;
    pbyte = 8'h00;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.add_len = 1'b1;
          word_d = in_word_i;
          cnt_d  = sat;
          fin_d  = in_final_i;
          pcnt_d = '0;
          if (sat != 3'd0) st_d = StBytes;
          else if (in_final_i) st_d = StPad;
        end
      end
      StBytes: begin
        cmd_o.push = 1'b1;
        cmd_o.push_byte = word_q[31:24];
        word_d = {word_q[23:0], 8'h00};
        cnt_d = cnt_q - 3'd1;
        ret_d = 1'b0;
        if (last_push) st_d = StRound;
        else if (cnt_q == 3'd1) st_d = fin_q ? StPad : StIdle;
        if (cnt_q == 3'd1 && fin_q) blen_d = sts_i.bit_len;
      end
      StPad: begin
        // 0x80, zeros until the fill reaches byte 56 (wrapping into a second
        // block if needed), then the 64-bit length.
        if (pcnt_q == 4'd0) begin
          pbyte = PadByte;
          pcnt_d = 4'd1;
          if (!pad_q) blen_d = sts_i.bit_len;
          pad_d = 1'b1;
        end else if (pcnt_q == 4'd1 && sts_i.fill != LenPos) begin
          pbyte = 8'h00;
        end else begin
          pbyte = blen_q[63:56];
          blen_d = {blen_q[55:0], 8'h00};
          pcnt_d = pcnt_q + 4'd1;
        end
        cmd_o.push = 1'b1;
        cmd_o.push_byte = pbyte;
        ret_d = 1'b1;
        if (last_push) st_d = StRound;
      end
      StRound: begin
        if (sts_i.round == 6'd0 && !cmd_o.rnd_step && pcnt_q[3:0] == 4'hf) begin
          cmd_o.rnd_step = 1'b1;
        end
        cmd_o.rnd_step = 1'b1;
        if (sts_i.round == 6'(Rounds - 1)) st_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        if (!ret_q) begin
          st_d = (cnt_q == 3'd0) ? (fin_q ? StPad : StIdle) : StBytes;
        end else if (pcnt_q == 4'd9) begin
          st_d = StOut;
          oi_d = '0;
        end else begin
          st_d = StPad;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          oi_d = oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            pad_d = 1'b0;
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
    // Load round state the cycle the block completes.
    if (cmd_o.push && last_push) cmd_o.rnd_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; fin_q <= 1'b0; pad_q <= 1'b0;
      ret_q <= 1'b0; oi_q <= '0; pcnt_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; fin_q <= fin_d; pad_q <= pad_d;
      ret_q <= ret_d; oi_q <= oi_d; pcnt_q <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    blen_q <= blen_d;
  end

endmodule

// ===== hw/rtl/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher top level: joins controller and datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
// Usage:
//   Slave channel s_axis_*: tdata = {byte_count, message_word}, up to four
//   bytes an item, earliest byte in bits 31..24; tlast carries final_req and
//   marks the last item of a message. Master channel m_axis_*: eight digest
//   words, most significant first, tlast on the eighth.
// Flow: one item is taken when the block is idle; its valid bytes are
//   then pushed one at a time before the next item is taken.
//   Every 64th byte starts the 64 rounds and a fold on the single
//   shared round unit. A final item adds padding (0x80, zeros, then the
//   length: at least 9 pad bytes, plus more rounds and a fold if a second
//   block is needed) and eight output words, held while the receiver stalls.
// Reset: asynchronous, active low; the chaining hash returns to the initial
//   values, byte and length counters clear.
// Stall: the digest words hold on m_axis_tdata while m_axis_tready is low;
//   no new item is taken until all eight words have left.
module sha256_stream_hasher_core import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // message_word[31:0], byte_count[34:32]
  input  logic        s_axis_tlast,   // final_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32]
  output logic        m_axis_tlast    // last_word
);

  sha_cmd_t   cmd;
  sha_sts_t   sts;
  logic [2:0] cnt, oidx;
  word_t      rd_word;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_word_i  (s_axis_tdata[31:0]),
    .in_count_i (s_axis_tdata[34:32]),
    .in_final_i (s_axis_tlast),
    .in_count_o (cnt),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_idx_o  (oidx)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .in_count_i (cnt),
    .rd_idx_i   (oidx),
    .rd_word_o  (rd_word),
    .sts_o      (sts)
  );

  assign m_axis_tdata = {5'b0, oidx, rd_word};
  assign m_axis_tlast = (oidx == 3'd7);

  // Never take an item while digest words are pending.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");

  // Restart clears the byte fill.
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.restart |=> sts.fill == 6'd0) else $error("fill not cleared");

  // A block completes only at the end of the block buffer.
  a_start_at_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rnd_start |-> (cmd.push && sts.fill == 6'd63)) else $error("bad start");

endmodule
